// File: rtl/orl_pkg.sv
package orl_pkg;

  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CNT_OUT_W    = 5;
  localparam int unsigned DEF_CAPACITY = 16;

  // request codes
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } fsm_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic run;    // delete scan in progress
    logic found;  // match already seen nearer the head
  } cell_ctl_t;

endpackage

// File: rtl/orl_if.sv
interface orl_req_if import orl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface orl_res_if import orl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic signed [VAL_W-1:0] head_value;

  modport source (output valid, output status, output entry_count, output head_value,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input head_value,
                  output ready);
endinterface

// File: rtl/orl_cell.sv
module orl_cell import orl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] key,
  input  logic                    tok_in,
  input  logic signed [VAL_W-1:0] right_value,
  input  logic                    we,
  input  logic signed [VAL_W-1:0] wdata,
  output logic signed [VAL_W-1:0] value,
  output logic                    tok_out,
  output logic                    hit
);

  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    tok_r, tok_nxt;
  logic                    act;

  // token marks the cell under scan this cycle
  assign act = ctl.run & tok_in;
  assign hit = act & (ctl.found | (value_r == key));

  always_comb begin
    tok_nxt   = act;
    value_nxt = value_r;
    if (we) begin
      value_nxt = wdata;
    end else if (hit) begin
      value_nxt = right_value;  // close the gap
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value   = value_r;
  assign tok_out = tok_r;

endmodule

// File: rtl/ordered_ring_list_append_delete.sv
// Ordered ring list: a bounded sequence of signed 32-bit values, head first.
// in_req  (valid/ready): req_type 0 appends item_value after the last entry,
//                        req_type 1 deletes the first entry equal to item_value.
// out_res (valid/ready): one result item per request with status, entry_count
//                        and head_value (0 when the list is empty).
// Append, append-when-full and delete-when-empty write their result straight
// into the output register (or the holding register if out_res is stalled), so
// they run at one item per cycle while out_res is not stalled. A delete scans the
// row of cells one cell per cycle, head to last entry, carrying a token; the
// result is registered at the last entry, and in_req.ready stays low meanwhile.
// The output register holds a finished result while out_res is stalled; one
// more finished result is parked in a holding register, after which in_req
// ready stays low until the receiver takes the waiting item.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// stored values are not cleared; slots at or above the count never reach a result.
module ordered_ring_list_append_delete import orl_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  orl_req_if.sink     in_req,
  orl_res_if.source   out_res
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);  // count width
  localparam int unsigned IW = $clog2(CAPACITY);      // cell index width

  fsm_t state_r, state_nxt;

  logic [CW-1:0]           count_r;
  logic [IW-1:0]           step_r;
  logic                    found_r;
  logic signed [VAL_W-1:0] key_r;

  // output register and one holding slot
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [CNT_OUT_W-1:0]    out_count_r;
  logic signed [VAL_W-1:0] out_head_r;
  status_t                 pend_status_r;
  logic [CNT_OUT_W-1:0]    pend_count_r;
  logic signed [VAL_W-1:0] pend_head_r;

  // row of cells
  logic signed [VAL_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]     toks;
  logic [CAPACITY-1:0]     hits;
  logic [CAPACITY-1:0]     wes;
  cell_ctl_t               ctl;

  // sequencer outputs
  logic                    acc;
  logic                    out_free;
  logic                    app_go;
  logic                    del_go;
  logic                    fin;
  status_t                 fin_status;
  logic [CW-1:0]           fin_count;
  logic signed [VAL_W-1:0] fin_head;
  logic                    last_step;
  logic                    any_hit;

  assign acc      = in_req.valid & in_req.ready;
  assign out_free = ~out_valid_r | out_res.ready;
  assign any_hit  = |hits;
  assign last_step = (CW'(step_r) == (count_r - CW'(1)));

  assign ctl.run   = (state_r == S_SCAN);
  assign ctl.found = found_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    tok_in;
    logic signed [VAL_W-1:0] right_value;

    assign wes[i] = app_go & (count_r == CW'(i));

    if (i == 0) begin : g_first
      assign tok_in = (state_r == S_SCAN) & (step_r == '0);
    end else begin : g_mid
      assign tok_in = toks[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = vals[i];
    end else begin : g_inner
      assign right_value = vals[i+1];
    end

    orl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .key         (key_r),
      .tok_in      (tok_in),
      .right_value (right_value),
      .we          (wes[i]),
      .wdata       (in_req.item_value),
      .value       (vals[i]),
      .tok_out     (toks[i]),
      .hit         (hits[i])
    );
  end

  // sequencer outputs
  always_comb begin
    in_req.ready = (state_r == S_IDLE);
    app_go       = 1'b0;
    del_go       = 1'b0;
    fin          = 1'b0;
    fin_status   = ST_DONE;
    fin_count    = count_r;
    fin_head     = (count_r != '0) ? vals[0] : '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_req.req_type == REQ_APPEND) begin
            fin = 1'b1;
            if (count_r == CW'(CAPACITY)) begin
              fin_status = ST_FULL;
            end else begin
              app_go    = 1'b1;
              fin_count = count_r + CW'(1);
              fin_head  = (count_r == '0) ? in_req.item_value : vals[0];
            end
          end else begin
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              del_go = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (last_step) begin
          fin = 1'b1;
          if (found_r | any_hit) begin
            fin_count = count_r - CW'(1);
            // head cell already shifted unless it was the only entry
            fin_head  = (count_r == CW'(1)) ? '0 : vals[0];
          end else begin
            fin_status = ST_MISSING;
          end
        end
      end
      S_HOLD: begin
        in_req.ready = 1'b0;
      end
      default: begin
        in_req.ready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (del_go) begin
          state_nxt = S_SCAN;
        end else if (fin && !out_free) begin
          state_nxt = S_HOLD;
        end
      end
      S_SCAN: begin
        if (fin) begin
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin) begin
        count_r <= fin_count;
      end
      if (del_go) begin
        step_r  <= '0;
        found_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        step_r  <= step_r + IW'(1);
        found_r <= found_r | any_hit;
      end
      if ((fin && out_free) || (state_r == S_HOLD && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (del_go) begin
      key_r <= in_req.item_value;
    end
    if (fin && out_free) begin
      out_status_r <= fin_status;
      out_count_r  <= CNT_OUT_W'(fin_count);
      out_head_r   <= fin_head;
    end else if (fin) begin
      pend_status_r <= fin_status;
      pend_count_r  <= CNT_OUT_W'(fin_count);
      pend_head_r   <= fin_head;
    end else if (state_r == S_HOLD && out_free) begin
      out_status_r <= pend_status_r;
      out_count_r  <= pend_count_r;
      out_head_r   <= pend_head_r;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = out_status_r;
  assign out_res.entry_count = out_count_r;
  assign out_res.head_value  = out_head_r;

endmodule
